[hw/rtl/lpht_pkg.sv]
// shared types and constants of the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;

  localparam int TableSlots = 1024;
  localparam int ValueBits  = 32;
  localparam int KeyBits    = 64;
  localparam int SlotBits   = $clog2(TableSlots);
  localparam int CapBits    = $clog2(TableSlots + 1);
  localparam int PctBits    = 7;
  localparam int CfgIdxBits = 2;
  localparam int CfgBits    = 64;
  localparam int ModSteps   = KeyBits / 2;
  localparam int ModCntBits = $clog2(ModSteps);
  localparam int LoadBits   = CapBits + 1 + PctBits + 1;

  localparam logic [63:0] MixC1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixC2 = 64'h94d049bb133111eb;

  localparam logic [CfgIdxBits-1:0] CfgCapacity = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgMaxLoad  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgTombKey  = 2'd2;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_PUT    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    RSP_FOUND     = 3'd0,
    RSP_INSERTED  = 3'd1,
    RSP_NOT_FOUND = 3'd2,
    RSP_REJECTED  = 3'd3,
    RSP_FULL      = 3'd4
  } rsp_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic hash_step;
    logic mod_init;
    logic mod_step;
    logic probe_next;
    logic commit;
    logic load_calc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic skip;
    logic hash_last;
    logic mod_last;
    logic hit;
    logic empty;
    logic exhausted;
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/lpht_req_if.sv]
// request channel interface
`timescale 1ns / 1ps
`default_nettype none
interface lpht_req_if;
  import lpht_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [KeyBits-1:0]   lookup_key;
  logic [ValueBits-1:0] entry_value;
  modport source (output valid, req_type, lookup_key, entry_value, input ready);
  modport sink (input valid, req_type, lookup_key, entry_value, output ready);
endinterface
`default_nettype wire

[hw/rtl/lpht_rsp_if.sv]
// response channel interface
`timescale 1ns / 1ps
`default_nettype none
interface lpht_rsp_if;
  import lpht_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [ValueBits-1:0] value_out;
  logic [SlotBits-1:0]  slot_index;
  logic                 load_exceeded;
  logic [CapBits-1:0]   live_entries;
  modport source (output valid, status, value_out, slot_index, load_exceeded,
                  live_entries, input ready);
  modport sink (input valid, status, value_out, slot_index, load_exceeded,
                live_entries, output ready);
endinterface
`default_nettype wire

[hw/rtl/lpht_dp.sv]
// datapath: hash, modulo, slot memories, counters and load check
`timescale 1ns / 1ps
`default_nettype none
module lpht_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lpht_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [lpht_pkg::CfgBits-1:0]    cfg_data_i,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [lpht_pkg::KeyBits-1:0]    lookup_key_i,
  input  wire logic [lpht_pkg::ValueBits-1:0]  entry_value_i,
  input  wire lpht_pkg::cmd_t                 cmd_i,
  output lpht_pkg::sts_t                      sts_o,
  output logic [2:0]                          status_o,
  output logic [lpht_pkg::ValueBits-1:0]      value_out_o,
  output logic [lpht_pkg::SlotBits-1:0]       slot_index_o,
  output logic                                load_exceeded_o,
  output logic [lpht_pkg::CapBits-1:0]        live_entries_o
);
  import lpht_pkg::*;

  logic [CapBits-1:0]   cap_q;
  logic [PctBits-1:0]   maxl_q;
  logic [KeyBits-1:0]   tkey_q;
  logic [CapBits-1:0]   cap_eff;

  logic [1:0]           req_q;
  logic [KeyBits-1:0]   key_q;
  logic [ValueBits-1:0] val_q;
  logic                 skip_q;

  logic [2:0]           hcnt_q;
  logic [63:0]          op_q;
  logic [63:0]          acc_q;
  logic [63:0]          mul_c;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          prod;

  logic [KeyBits-1:0]   dvd_q;
  logic [CapBits-1:0]   rem_q;
  logic [ModCntBits-1:0] mcnt_q;
  logic [CapBits:0]     t1, t2, r1, r2;

  logic [SlotBits-1:0]  idx_q;
  logic [CapBits-1:0]   n_q;
  logic [CapBits-1:0]   idx_inc;
  logic [SlotBits-1:0]  clr_q;

  logic [KeyBits-1:0]   key_mem [TableSlots];
  logic [ValueBits-1:0] val_mem [TableSlots];
  logic [1:0]           st_mem  [TableSlots];
  logic [KeyBits-1:0]   rd_key_q;
  logic [ValueBits-1:0] rd_val_q;
  logic [1:0]           rd_st_q;

  logic                 hit, empty, exhausted;
  logic                 key_we, val_we, st_we;
  logic [1:0]           st_wdata;
  logic [SlotBits-1:0]  st_waddr;

  logic [CapBits-1:0]   live_q, tomb_q;
  logic [CapBits:0]     used;
  logic [LoadBits-1:0]  lhs_q, rhs_q;

  logic [2:0]           res_status_q;
  logic [ValueBits-1:0] res_value_q;
  logic [SlotBits-1:0]  res_slot_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapBits'(TableSlots);
      maxl_q <= PctBits'(75);
      tkey_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCapacity: cap_q  <= cfg_data_i[CapBits-1:0];
        CfgMaxLoad:  maxl_q <= cfg_data_i[PctBits-1:0];
        CfgTombKey:  tkey_q <= cfg_data_i[KeyBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CapBits'(1);
    end else if (cap_q > CapBits'(TableSlots)) begin
      cap_eff = CapBits'(TableSlots);
    end else begin
      cap_eff = cap_q;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q  <= req_type_i;
      key_q  <= lookup_key_i;
      val_q  <= entry_value_i;
      skip_q <= (req_type_i == REQ_NONE) ||
                ((req_type_i == REQ_PUT) && (lookup_key_i == tkey_q));
    end
  end

  // hash: one 32x32 partial product per step
  assign mul_c = (hcnt_q > 3'd3) ? MixC2 : MixC1;
  assign mul_a = (hcnt_q == 3'd2 || hcnt_q == 3'd6) ? op_q[63:32] : op_q[31:0];
  assign mul_b = (hcnt_q == 3'd1 || hcnt_q == 3'd5) ? mul_c[63:32] : mul_c[31:0];
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= '0;
    end else if (cmd_i.accept) begin
      hcnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      hcnt_q <= hcnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= lookup_key_i ^ (lookup_key_i >> 30);
    end else if (cmd_i.hash_step) begin
      unique case (hcnt_q)
        3'd0, 3'd4: acc_q <= prod;
        3'd1, 3'd2, 3'd5, 3'd6: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
        3'd3: op_q <= acc_q ^ (acc_q >> 27);
        default: ;
      endcase
    end
  end

  // modulo: restoring reduction, two dividend bits per step
  always_comb begin
    t1 = {rem_q, dvd_q[KeyBits-1]};
    r1 = (t1 >= {1'b0, cap_eff}) ? t1 - {1'b0, cap_eff} : t1;
    t2 = {r1[CapBits-1:0], dvd_q[KeyBits-2]};
    r2 = (t2 >= {1'b0, cap_eff}) ? t2 - {1'b0, cap_eff} : t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (cmd_i.mod_init) begin
      mcnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      mcnt_q <= mcnt_q + ModCntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_init) begin
      dvd_q <= acc_q ^ (acc_q >> 31);
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      dvd_q <= dvd_q << 2;
      rem_q <= r2[CapBits-1:0];
    end
  end

  // probe position
  assign idx_inc = CapBits'(idx_q) + CapBits'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_step && sts_o.mod_last) begin
      idx_q <= r2[SlotBits-1:0];
      n_q   <= '0;
    end else if (cmd_i.probe_next) begin
      idx_q <= (idx_inc == cap_eff) ? '0 : idx_inc[SlotBits-1:0];
      n_q   <= n_q + CapBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + SlotBits'(1);
    end
  end

  assign hit       = (rd_st_q == SLOT_LIVE) && (rd_key_q == key_q);
  assign empty     = (rd_st_q == SLOT_EMPTY);
  assign exhausted = (n_q + CapBits'(1)) == cap_eff;

  // memory writes
  always_comb begin
    key_we   = 1'b0;
    val_we   = 1'b0;
    st_we    = 1'b0;
    st_wdata = SLOT_EMPTY;
    st_waddr = idx_q;
    if (cmd_i.clr_step) begin
      st_we    = 1'b1;
      st_waddr = clr_q;
    end else if (cmd_i.commit) begin
      if (hit && req_q == REQ_PUT) begin
        val_we = 1'b1;
      end else if (hit && req_q == REQ_REMOVE) begin
        st_we    = 1'b1;
        st_wdata = SLOT_TOMB;
      end else if (!hit && empty && req_q == REQ_PUT) begin
        key_we   = 1'b1;
        val_we   = 1'b1;
        st_we    = 1'b1;
        st_wdata = SLOT_LIVE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[idx_q] <= key_q;
    end
    if (val_we) begin
      val_mem[idx_q] <= val_q;
    end
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    rd_key_q <= key_mem[idx_q];
    rd_val_q <= val_mem[idx_q];
    rd_st_q  <= st_mem[idx_q];
  end

  // occupancy counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      tomb_q <= '0;
    end else if (cmd_i.commit) begin
      if (hit && req_q == REQ_REMOVE) begin
        live_q <= live_q - CapBits'(1);
        tomb_q <= tomb_q + CapBits'(1);
      end else if (!hit && empty && req_q == REQ_PUT) begin
        live_q <= live_q + CapBits'(1);
      end
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_status_q <= ((req_type_i == REQ_PUT) && (lookup_key_i == tkey_q)) ?
                      RSP_REJECTED : RSP_NOT_FOUND;
      res_value_q  <= '0;
      res_slot_q   <= '0;
    end else if (cmd_i.commit) begin
      if (hit) begin
        res_status_q <= RSP_FOUND;
        res_value_q  <= rd_val_q;
        res_slot_q   <= idx_q;
      end else if (empty && req_q == REQ_PUT) begin
        res_status_q <= RSP_INSERTED;
        res_slot_q   <= idx_q;
      end else if (!empty && req_q == REQ_PUT) begin
        res_status_q <= RSP_FULL;
      end
    end
  end

  // load check: used*100 >= (limit+1)*capacity
  assign used = {1'b0, live_q} + {1'b0, tomb_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_calc) begin
      lhs_q <= LoadBits'(used) * LoadBits'(100);
      rhs_q <= (LoadBits'(maxl_q) + LoadBits'(1)) * LoadBits'(cap_eff);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o        <= res_status_q;
      value_out_o     <= res_value_q;
      slot_index_o    <= res_slot_q;
      load_exceeded_o <= (lhs_q >= rhs_q);
      live_entries_o  <= live_q;
    end
  end

  assign sts_o.clr_last  = (clr_q == SlotBits'(TableSlots - 1));
  assign sts_o.skip      = skip_q;
  assign sts_o.hash_last = (hcnt_q == 3'd6);
  assign sts_o.mod_last  = (mcnt_q == ModCntBits'(ModSteps - 1));
  assign sts_o.hit       = hit;
  assign sts_o.empty     = empty;
  assign sts_o.exhausted = exhausted;

endmodule
`default_nettype wire

[hw/rtl/lpht_ctrl.sv]
// controller state machine of the hash table
`timescale 1ns / 1ps
`default_nettype none
module lpht_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire lpht_pkg::sts_t sts_i,
  output lpht_pkg::cmd_t      cmd_o
);
  import lpht_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_HASH  = 9'b000000100,
    ST_MINIT = 9'b000001000,
    ST_MOD   = 9'b000010000,
    ST_READ  = 9'b000100000,
    ST_CHECK = 9'b001000000,
    ST_LOAD  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_HASH;
        end
      end
      ST_HASH: begin
        if (sts_i.skip) begin
          state_d = ST_LOAD;
        end else begin
          cmd_o.hash_step = 1'b1;
          if (sts_i.hash_last) begin
            state_d = ST_MINIT;
          end
        end
      end
      ST_MINIT: begin
        cmd_o.mod_init = 1'b1;
        state_d        = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.hit || sts_i.empty || sts_i.exhausted) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_LOAD;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = ST_READ;
        end
      end
      ST_LOAD: begin
        cmd_o.load_calc = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[hw/rtl/linear_probe_hash_table_unit.sv]
// top level of the linear probing hash table
//
//   channel  dir  transfer             payload
//   req      in   req.valid&req.ready  req_type, lookup_key, entry_value
//   rsp      out  rsp.valid&rsp.ready  status, value_out, slot_index, load_exceeded,
//                                      live_entries
//   cfg      in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// a request passes through the accepting state, 7 hash steps on one 32x32
// multiplier, a modulo setup state, 32 steps of the modulo unit, a registered
// slot memory read and a check for each slot probed, a load check state and
// an output state; a rejected or unused request skips the hash, modulo and
// probe steps. after reset a clearing pass over all 1024 slots empties the slot
// status memory; no request is taken meanwhile. a finished response waits in
// the output register while the next request is taken; the one after that
// stalls until the waiting response is transferred.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lpht_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [lpht_pkg::CfgBits-1:0]    cfg_data_i,
  lpht_req_if.sink                             req,
  lpht_rsp_if.source                           rsp
);
  import lpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lpht_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req.req_type),
    .lookup_key_i    (req.lookup_key),
    .entry_value_i   (req.entry_value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (rsp.status),
    .value_out_o     (rsp.value_out),
    .slot_index_o    (rsp.slot_index),
    .load_exceeded_o (rsp.load_exceeded),
    .live_entries_o  (rsp.live_entries)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in progress");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.live_entries <= CapBits'(TableSlots)))
    else $error("live entry count beyond table size");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status == RSP_INSERTED) |-> (rsp.live_entries != '0))
    else $error("insert reported with no live entry");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.commit, cmd.probe_next, cmd.out_load, cmd.clr_step}))
    else $error("conflicting controller commands");

endmodule
`default_nettype wire

[test/tb_checker.sv]
// scoreboard for the hash table: tracks table state, predicts and compares responses
`timescale 1ns / 1ps
module tb_checker
  import lpht_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  lpht_req_if                   req,
  lpht_rsp_if                   rsp,
  output int                    errors_o,
  output int                    pending_o
);

  typedef struct {
    rsp_e                 status;
    logic [ValueBits-1:0] value;
    logic [SlotBits-1:0]  slot;
    logic                 load_hi;
    logic [CapBits-1:0]   live;
  } answer_t;

  answer_t              answer_q[$];
  logic [KeyBits-1:0]   key_mem[TableSlots];
  logic [ValueBits-1:0] val_mem[TableSlots];
  slot_e                state_mem[TableSlots];
  int                   live_cnt;
  int                   tomb_cnt;
  logic [CapBits-1:0]   cap_reg;
  logic [PctBits-1:0]   pct_reg;
  logic [KeyBits-1:0]   tomb_key_reg;

  initial begin
    for (int i = 0; i < TableSlots; i++) state_mem[i] = SLOT_EMPTY;
    live_cnt = 0;
    tomb_cnt = 0;
    cap_reg = CapBits'(TableSlots);
    pct_reg = 7'd75;
    tomb_key_reg = '1;
    errors_o = 0;
    pending_o = 0;
  end

  function automatic int slots_used();
    if (cap_reg == 0) return 1;
    if (cap_reg > TableSlots) return TableSlots;
    return int'(cap_reg);
  endfunction

  function automatic logic [63:0] splitmix(logic [63:0] k);
    k = (k ^ (k >> 30)) * MixC1;
    k = (k ^ (k >> 27)) * MixC2;
    return k ^ (k >> 31);
  endfunction

  // walk the probe chain; returns 1 on a live key match
  function automatic bit walk(logic [63:0] k, output int pos, output bit hit_empty);
    int cap;
    int i;
    cap = slots_used();
    i = int'(splitmix(k) % 64'(cap));
    pos = 0;
    hit_empty = 0;
    for (int n = 0; n < cap; n++) begin
      if (state_mem[i] == SLOT_EMPTY) begin
        hit_empty = 1;
        pos = i;
        return 0;
      end
      if (state_mem[i] == SLOT_LIVE && key_mem[i] == k) begin
        pos = i;
        return 1;
      end
      i = (i + 1 == cap) ? 0 : i + 1;
    end
    return 0;
  endfunction

  function automatic answer_t serve_request(req_e op, logic [63:0] k, logic [31:0] v);
    answer_t a;
    int pos;
    bit hit_empty;
    int load;
    a.status = RSP_NOT_FOUND;
    a.value = '0;
    a.slot = '0;
    case (op)
      REQ_GET: begin
        if (walk(k, pos, hit_empty)) begin
          a.status = RSP_FOUND;
          a.value = val_mem[pos];
          a.slot = SlotBits'(pos);
        end
      end
      REQ_PUT: begin
        if (k == tomb_key_reg) begin
          a.status = RSP_REJECTED;
        end else if (walk(k, pos, hit_empty)) begin
          a.status = RSP_FOUND;
          a.value = val_mem[pos];
          a.slot = SlotBits'(pos);
          val_mem[pos] = v;
        end else if (hit_empty) begin
          a.status = RSP_INSERTED;
          a.slot = SlotBits'(pos);
          key_mem[pos] = k;
          val_mem[pos] = v;
          state_mem[pos] = SLOT_LIVE;
          live_cnt++;
        end else begin
          a.status = RSP_FULL;
        end
      end
      REQ_REMOVE: begin
        if (walk(k, pos, hit_empty)) begin
          a.status = RSP_FOUND;
          a.value = val_mem[pos];
          a.slot = SlotBits'(pos);
          state_mem[pos] = SLOT_TOMB;
          live_cnt--;
          tomb_cnt++;
        end
      end
      default: ;
    endcase
    load = ((live_cnt + tomb_cnt) * 100) / slots_used();
    a.load_hi = load > int'(pct_reg);
    a.live = CapBits'(live_cnt);
    return a;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCapacity: cap_reg = cfg_data_i[CapBits-1:0];
          CfgMaxLoad:  pct_reg = cfg_data_i[PctBits-1:0];
          CfgTombKey:  tomb_key_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        answer_q.push_back(serve_request(req_e'(req.req_type), req.lookup_key,
                                         req.entry_value));
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          errors_o++;
          $display("%0t unexpected transfer: status %0d value %h slot %0d", $time,
                   rsp.status, rsp.value_out, rsp.slot_index);
        end else begin
          want = answer_q.pop_front();
          if (rsp.status !== want.status || rsp.value_out !== want.value ||
              rsp.slot_index !== want.slot || rsp.load_exceeded !== want.load_hi ||
              rsp.live_entries !== want.live) begin
            errors_o++;
            $display("%0t mismatch exp st %0d val %h slot %0d load %b live %0d",
                     $time, want.status, want.value, want.slot, want.load_hi, want.live);
            $display("%0t          act st %0d val %h slot %0d load %b live %0d",
                     $time, rsp.status, rsp.value_out, rsp.slot_index,
                     rsp.load_exceeded, rsp.live_entries);
          end
        end
      end
      pending_o = answer_q.size();
    end
  end

endmodule

[test/tb.sv]
// testbench top: drives requests and configuration, reports the verdict
`timescale 1ns / 1ps
module tb;
  import lpht_pkg::*;

  localparam int CycleLimit = 12000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgBits-1:0]    cfg_data = '0;
  int                    errors;
  int                    pending;
  int                    cycles = 0;
  bit                    calm = 0;
  bit                    long_hold = 0;
  logic [KeyBits-1:0]    tomb_key = '1;
  logic [KeyBits-1:0]    key_pool[$];

  lpht_req_if req_bus ();
  lpht_rsp_if rsp_bus ();

  linear_probe_hash_table_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_bus),
    .rsp        (rsp_bus)
  );

  tb_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    req_bus.valid = 1'b0;
    req_bus.req_type = '0;
    req_bus.lookup_key = '0;
    req_bus.entry_value = '0;
    rsp_bus.ready = 1'b0;
  end

  // response side: random stalls, one long hold-off on request
  initial begin
    repeat (10) @(posedge clk_i);
    forever begin
      if (long_hold) begin
        rsp_bus.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 0;
      end else if (calm) begin
        rsp_bus.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  end

  task automatic send(req_e op, logic [63:0] k, logic [31:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= op;
    req_bus.lookup_key <= k;
    req_bus.entry_value <= v;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return tomb_key;
    if (r < 8 || key_pool.size() == 0) return rand_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  function automatic req_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return REQ_PUT;
    if (r < 80) return REQ_GET;
    if (r < 95) return REQ_REMOVE;
    return REQ_NONE;
  endfunction

  initial begin
    int          caps[7]  = '{1, 0, 4, 16, 64, 256, 2047};
    int          counts[7] = '{60, 60, 150, 250, 350, 450, 480};
    int          pcts[7]  = '{0, 100, 127, 50, 33, 75, 100};
    int          pool_n;
    logic [63:0] k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings
    k = rand_key();
    send(REQ_PUT, '1, 32'h1234_5678);
    send(REQ_GET, '1, '0);
    send(REQ_REMOVE, '1, '0);
    send(REQ_GET, k, '0);
    send(REQ_PUT, k, '1);
    send(REQ_GET, k, '0);
    send(REQ_PUT, k, '0);
    send(REQ_GET, k, '1);
    send(REQ_PUT, '0, 32'hdead_beef);
    send(REQ_GET, '0, '0);
    send(REQ_REMOVE, k, '0);
    send(REQ_GET, k, '0);
    send(REQ_REMOVE, k, '0);
    send(REQ_PUT, k, 32'h5555_aaaa);
    send(REQ_NONE, '0, '1);
    send(REQ_NONE, '1, '0);
    send(REQ_REMOVE, '0, '0);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        2: tomb_key = '0;
        6: tomb_key = '1;
        default: tomb_key = rand_key();
      endcase
      write_reg(CfgCapacity, 64'(caps[p]));
      write_reg(CfgMaxLoad, 64'(pcts[p]));
      write_reg(CfgTombKey, tomb_key);
      key_pool.delete();
      pool_n = (caps[p] < 1 ? 1 : caps[p]) * 3 / 2 + 4;
      if (pool_n > 400) pool_n = 400;
      for (int i = 0; i < pool_n; i++) key_pool.push_back(rand_key());
      calm = (p == 6);
      for (int n = 0; n < counts[p]; n++) begin
        if (p == 4 && n == 100) long_hold = 1;
        send(pick_op(), pick_key(), $urandom());
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[linear_probe_hash_table_unit.f]
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_req_if.sv
hw/rtl/lpht_rsp_if.sv
hw/rtl/lpht_dp.sv
hw/rtl/lpht_ctrl.sv
hw/rtl/linear_probe_hash_table_unit.sv
test/tb_checker.sv
test/tb.sv
